// ===== hdl/udec_pkg.sv =====
package udec_pkg;

	// Input and result field widths
	localparam int VALUE_W       = 32;
	localparam int CHAR_W        = 6;
	localparam int VALUE_BITS_DEF = 32;

	// A 32-bit input never has more than ten decimal digits
	localparam int MAX_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int CNT_W      = 4;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// Divide by ten: q = (v * RECIP) >> RECIP_SHIFT, exact for any 32-bit v
	localparam int            MUL_W       = 2 * VALUE_W;
	localparam logic [31:0]   RECIP       = 32'hCCCC_CCCD;
	localparam int            RECIP_SHIFT = 35;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic divide;
		logic emit;
	} udec_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic quot_zero;
		logic cnt_last;
		logic emit_last;
		logic out_free;
	} udec_stat_t;

endpackage

// ===== hdl/unsigned_to_decimal_ascii.sv =====
// Unsigned binary to decimal ASCII converter.
//
// Input channel (in_valid/in_ready/value): one transaction carries one
// unsigned number; only its low VALUE_BITS bits (at most 32) are converted.
// Output channel (out_valid/out_ready/digit_char/last): one transaction per
// decimal digit, ASCII '0'..'9', most significant first, leading zeros
// suppressed, last set on the least significant digit. Zero gives one '0'.
//
// An n-digit number (1 <= n <= 10) is loaded, divided by ten once per
// digit (one reciprocal multiply per cycle, the product registered before
// the next digit), then its digits are emitted from the digit buffer.
// The next value is accepted once the previous last digit sits in the
// output register. When out_ready is low the current digit holds and the
// converter waits. Reset clears the controller and the output valid; no
// clearing pass is needed.
module unsigned_to_decimal_ascii
	import udec_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last
);

	udec_cmd_t  cmd;
	udec_stat_t stat;

	udec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	udec_dpath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

// ===== hdl/udec_ctrl.sv =====
module udec_ctrl
	import udec_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  udec_stat_t stat,
	output udec_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// Decode commands and next state
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.divide = 1'b0;
		cmd.emit   = 1'b0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.divide = 1'b1;
				if (stat.quot_zero || stat.cnt_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/udec_dpath.sv =====
module udec_dpath
	import udec_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [VALUE_W-1:0] value,
	input  udec_cmd_t          cmd,
	output udec_stat_t         stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last
);

	// Only the low bits up to the field width take part
	localparam int EFF_BITS = (VALUE_BITS > VALUE_W) ? VALUE_W : VALUE_BITS;

	logic [EFF_BITS-1:0] val_q;
	logic [MUL_W-1:0]    prod_q;
	logic [EFF_BITS-1:0] quot;
	logic [EFF_BITS-1:0] diff;
	logic [VALUE_W-1:0]  mul_a;
	logic [DIGIT_W-1:0]  digit_mem [MAX_DIGITS];
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    rd_idx;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;

	// Quotient from the registered product, remainder by shift and add
	assign quot  = EFF_BITS'(prod_q >> RECIP_SHIFT);
	assign diff  = val_q - ((quot << 3) + (quot << 1));
	assign mul_a = cmd.load ? VALUE_W'(value[EFF_BITS-1:0]) : VALUE_W'(quot);

	assign rd_idx = cnt_q - CNT_W'(1);

	assign stat.quot_zero = (quot == '0);
	assign stat.cnt_last  = (cnt_q == CNT_W'(MAX_DIGITS - 1));
	assign stat.emit_last = (cnt_q == CNT_W'(1));
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last       = last_q;

	// Hold the remaining value and its product with the reciprocal
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value[EFF_BITS-1:0];
		end else if (cmd.divide) begin
			val_q <= quot;
		end
		if (cmd.load || cmd.divide) begin
			prod_q <= MUL_W'(mul_a) * MUL_W'(RECIP);
		end
	end

	// Store digits least significant first
	always_ff @(posedge clk) begin
		if (cmd.divide) begin
			digit_mem[cnt_q] <= diff[DIGIT_W-1:0];
		end
	end

	// Count digits up while dividing, down while emitting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.divide) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.emit) begin
			cnt_q <= rd_idx;
		end
	end

	// Output register: load a digit, drop it once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= ASCII_ZERO + CHAR_W'(digit_mem[rd_idx]);
			last_q <= stat.emit_last;
		end
	end

endmodule

// ===== tb/unsigned_to_decimal_ascii_test.sv =====
module unsigned_to_decimal_ascii_test;
	import udec_pkg::*;

	localparam int VALUE_BITS  = VALUE_BITS_DEF;
	localparam int N_ITEMS     = 230;
	localparam int N_STEADY    = 40;
	localparam int DRAIN       = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_DIR       = 18;

	// One emitted digit as it should appear on the result channel
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_t;

	// Directed row: empty digit text means the predictor supplies the digits
	typedef struct {
		logic [VALUE_W-1:0] value;
		string              digits;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [VALUE_W-1:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [CHAR_W-1:0]  digit_char;
	logic               last;

	digit_t pending_digits [$];
	int     fault_count = 0;
	int     cycle_count = 0;
	logic   steady = 1'b0;

	dir_row_t dir_rows [N_DIR] = '{
		'{32'd0,          "0"},
		'{32'd1,          "1"},
		'{32'd9,          "9"},
		'{32'd10,         "10"},
		'{32'd99,         "99"},
		'{32'd100,        "100"},
		'{32'hFFFF_FFFF,  "4294967295"},
		'{32'd1000000000, "1000000000"},
		'{32'd999999999,  "999999999"},
		'{32'h8000_0000,  "2147483648"},
		'{32'h7FFF_FFFF,  ""},
		'{32'hFFFF_FFFE,  ""},
		'{32'h5555_5555,  ""},
		'{32'hAAAA_AAAA,  ""},
		'{32'd4000000000, ""},
		'{32'd12345,      ""},
		'{32'd7,          ""},
		'{32'd1000,       ""}
	};

	unsigned_to_decimal_ascii #(
		.VALUE_BITS(VALUE_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.digit_char(digit_char),
		.last      (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Split the converted part of a value into decimal digits, most significant first
	function automatic void decimal_digits_of(logic [VALUE_W-1:0] v);
		logic [63:0] mask;
		logic [63:0] rest;
		logic [3:0]  lsd_first [MAX_DIGITS];
		int          count;
		digit_t      d;
		mask  = (VALUE_BITS >= VALUE_W) ? 64'hFFFF_FFFF : ((64'd1 << VALUE_BITS) - 64'd1);
		rest  = {32'd0, v} & mask;
		count = 0;
		do begin
			lsd_first[count] = 4'(rest % 64'd10);
			rest = rest / 64'd10;
			count++;
		end while (rest != 64'd0 && count < MAX_DIGITS);
		for (int k = 0; k < count; k++) begin
			d.ch   = ASCII_ZERO + CHAR_W'(lsd_first[count - 1 - k]);
			d.last = (k == count - 1);
			pending_digits.push_back(d);
		end
	endfunction

	// Drive values: directed rows, then random values spread over digit counts
	initial begin
		logic [VALUE_W-1:0] v;
		logic [63:0]        lo;
		logic [63:0]        hi;
		string              txt;
		int                 ndig;
		digit_t             d;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		value    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int i = 0; i < N_ITEMS; i++) begin
			steady = (i >= N_ITEMS - N_STEADY) || (i >= 120 && i < 150);
			if (i < N_DIR) begin
				v   = dir_rows[i].value;
				txt = dir_rows[i].digits;
			end else begin
				txt = "";
				if ($urandom_range(0, 3) == 0) begin
					v = $urandom;
				end else begin
					ndig = $urandom_range(1, MAX_DIGITS);
					lo   = (ndig == 1) ? 64'd0 : 64'd1;
					for (int k = 1; k < ndig; k++)
						lo = lo * 64'd10;
					hi = (ndig == MAX_DIGITS) ? 64'hFFFF_FFFF :
						((lo == 64'd0) ? 64'd9 : lo * 64'd10 - 64'd1);
					v  = $urandom_range(32'(hi), 32'(lo));
				end
			end
			// Hold off with noise on the payload
			if (!steady && $urandom_range(0, 3) == 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 11)) begin
					value = $urandom;
					@(negedge clk);
				end
			end
			in_valid = 1'b1;
			value    = v;
			do @(posedge clk); while (!in_ready);
			if (txt.len() == 0) begin
				decimal_digits_of(v);
			end else begin
				for (int k = 0; k < txt.len(); k++) begin
					d.ch   = CHAR_W'(txt[k]);
					d.last = (k == txt.len() - 1);
					pending_digits.push_back(d);
				end
			end
			@(negedge clk);
		end
		in_valid = 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fault_count == 0) begin
			$display("unsigned_to_decimal_ascii test passed");
		end else begin
			$display("unsigned_to_decimal_ascii test failed");
		end
		$finish;
	end

	// Stall the result side in random bursts, none while steady
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (steady) begin
				stall_left = 0;
				out_ready  = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				out_ready  = 1'b0;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Compare each digit transaction with the oldest pending digit
	always @(posedge clk) begin
		digit_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_digits.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected digit %c last=%0b", 8'(digit_char) + 8'd0, last);
			end else begin
				want = pending_digits.pop_front();
				if (want.ch !== digit_char || want.last !== last) begin
					fault_count++;
					if (fault_count <= 10)
						$display("digit mismatch: expected %0d last=%0b, got %0d last=%0b",
							want.ch, want.last, digit_char, last);
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("unsigned_to_decimal_ascii test failed");
			$finish;
		end
	end

endmodule
